// File: hdl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

    localparam int COORD_W       = 32;
    localparam int COEF_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 64;
    localparam int CFG_N         = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int PROD_W        = COEF_W + COORD_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int DMW           = ACC_W - 1;
    localparam int QB            = COORD_W + 1;

    localparam logic [CFG_IDX_W-1:0] IDX_R3_C01 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] IDX_R3_C23 = CFG_IDX_W'(7);

    typedef logic [CFG_N-1:0][CFG_W-1:0] t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      w_zero;
        logic                      overflowed;
    } t_out;

    typedef struct packed {
        logic [DMW-1:0] rem;
        logic [QB-1:0]  sh;
        logic           neg;
        logic           big;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0] lane;
        logic [DMW-1:0]  dvs;
        logic            wz;
    } t_div_beat;

    function automatic t_cfg cfg_reset(input int frac);
        t_cfg v;
        logic [COEF_W-1:0] one;
        one = COEF_W'(1) << frac;
        v = '0;
        v[0] = CFG_W'(one);
        v[2] = {one, {COEF_W{1'b0}}};
        v[5] = CFG_W'(one);
        v[7] = {one, {COEF_W{1'b0}}};
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/hpt_front.sv
`default_nettype none
module hpt_front import hpt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    input  wire t_cfg i_cfg,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_div_beat o_beat
);

    localparam int NMW = DMW + FRAC_BITS;
    localparam logic [COEF_W-1:0] ONE_FX = COEF_W'(1) << FRAC_BITS;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    logic signed [PROD_W-1:0] r_prod [4][3];
    logic signed [PROD_W-1:0] n_prod [4][3];
    logic signed [COEF_W-1:0] r_trans [4];
    logic signed [COEF_W-1:0] n_trans [4];
    logic signed [ACC_W-1:0]  r_acc [4];
    logic signed [ACC_W-1:0]  n_acc [4];
    logic [NMW-1:0]           r_nm [3];
    logic [NMW-1:0]           n_nm [3];
    logic [DMW-1:0]           r_dm, n_dm;
    logic [2:0]               r_neg, n_neg;
    logic                     r_wz, n_wz;
    t_div_beat                r_beat, n_beat;
    logic                     w_div;

    assign adv4    = ~r_v4 | i_ready;
    assign adv3    = ~r_v3 | adv4;
    assign adv2    = ~r_v2 | adv3;
    assign adv1    = ~r_v1 | adv2;
    assign o_ready = adv1;
    assign o_valid = r_v4;
    assign o_beat  = r_beat;

    assign w_div = !(i_cfg[IDX_R3_C01][COEF_W-1:0] == '0 &&
                     i_cfg[IDX_R3_C01][CFG_W-1 -: COEF_W] == '0 &&
                     i_cfg[IDX_R3_C23][COEF_W-1:0] == '0 &&
                     i_cfg[IDX_R3_C23][CFG_W-1 -: COEF_W] == ONE_FX);

    always_comb begin
        logic signed [COORD_W-1:0] pts [3];
        logic signed [COEF_W-1:0]  coef;
        pts[0] = i_data.point_x;
        pts[1] = i_data.point_y;
        pts[2] = i_data.point_z;
        for (int r = 0; r < 4; r++) begin
            n_trans[r] = i_cfg[r*2+1][CFG_W-1 -: COEF_W];
            for (int c = 0; c < 3; c++) begin
                coef = i_cfg[r*2 + (c >> 1)][(c & 1)*COEF_W +: COEF_W];
                n_prod[r][c] = PROD_W'(coef) * PROD_W'(pts[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_acc[r] = (ACC_W'(r_trans[r]) <<< FRAC_BITS) + ACC_W'(r_prod[r][0])
                       + ACC_W'(r_prod[r][1]) + ACC_W'(r_prod[r][2]);
        end
    end

    always_comb begin
        logic [ACC_W-1:0] neg_v;
        logic [DMW-1:0]   mag [4];
        for (int r = 0; r < 4; r++) begin
            neg_v  = -r_acc[r];
            mag[r] = r_acc[r][ACC_W-1] ? neg_v[DMW-1:0] : r_acc[r][DMW-1:0];
        end
        n_wz = w_div && (r_acc[3] == '0);
        for (int c = 0; c < 3; c++) begin
            n_nm[c]  = w_div ? {mag[c], {FRAC_BITS{1'b0}}} : NMW'(mag[c]);
            n_neg[c] = r_acc[c][ACC_W-1] ^ (w_div & r_acc[3][ACC_W-1]);
        end
        if (!w_div) begin
            n_dm = DMW'(1) << FRAC_BITS;
        end else if (n_wz) begin
            n_dm = DMW'(1);
        end else begin
            n_dm = mag[3];
        end
    end

    always_comb begin
        logic [NMW-1:0] hi;
        n_beat.dvs = r_dm;
        n_beat.wz  = r_wz;
        for (int c = 0; c < 3; c++) begin
            hi                = r_nm[c] >> QB;
            n_beat.lane[c].big = hi >= NMW'(r_dm);
            n_beat.lane[c].rem = hi[DMW-1:0];
            n_beat.lane[c].sh  = r_nm[c][QB-1:0];
            n_beat.lane[c].neg = r_neg[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_prod  <= n_prod;
            r_trans <= n_trans;
        end
        if (adv2) begin
            r_acc <= n_acc;
        end
        if (adv3) begin
            r_nm  <= n_nm;
            r_dm  <= n_dm;
            r_neg <= n_neg;
            r_wz  <= n_wz;
        end
        if (adv4) begin
            r_beat <= n_beat;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hpt_div_cell.sv
`default_nettype none
module hpt_div_cell import hpt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_beat i_beat,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_beat      o_beat
);

    logic      r_v;
    logic      adv;
    t_div_beat r_beat, n_beat;

    assign adv     = ~r_v | i_ready;
    assign o_ready = adv;
    assign o_valid = r_v;
    assign o_beat  = r_beat;

    always_comb begin
        logic [DMW:0] trial;
        logic [DMW:0] diff;
        logic         ge;
        n_beat = i_beat;
        for (int c = 0; c < 3; c++) begin
            trial = {i_beat.lane[c].rem, i_beat.lane[c].sh[QB-1]};
            diff  = trial - {1'b0, i_beat.dvs};
            ge    = trial >= {1'b0, i_beat.dvs};
            n_beat.lane[c].rem = ge ? diff[DMW-1:0] : trial[DMW-1:0];
            n_beat.lane[c].sh  = {i_beat.lane[c].sh[QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_beat <= n_beat;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hpt_round.sv
`default_nettype none
module hpt_round import hpt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_beat i_beat,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out           o_data
);

    localparam logic [QB:0] POS_LIM = (QB+1)'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] MAXV = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] MINV = {1'b1, {(COORD_W-1){1'b0}}};

    logic r_v;
    logic adv;
    t_out r_data, n_data;

    assign adv     = ~r_v | i_ready;
    assign o_ready = adv;
    assign o_valid = r_v;
    assign o_data  = r_data;

    always_comb begin
        logic [COORD_W-1:0] res [3];
        logic [QB:0]        qm;
        logic [COORD_W-1:0] qn;
        logic               inc;
        logic               sat;
        logic               ovf;
        ovf = 1'b0;
        for (int c = 0; c < 3; c++) begin
            inc = {i_beat.lane[c].rem, 1'b0} >= {1'b0, i_beat.dvs};
            qm  = (QB+1)'(i_beat.lane[c].sh) + (QB+1)'(inc);
            qn  = -qm[COORD_W-1:0];
            sat = i_beat.lane[c].big ||
                  (i_beat.lane[c].neg ? (qm > POS_LIM) : (qm >= POS_LIM));
            if (sat) begin
                res[c] = i_beat.lane[c].neg ? MINV : MAXV;
            end else begin
                res[c] = i_beat.lane[c].neg ? qn : qm[COORD_W-1:0];
            end
            ovf = ovf | sat;
        end
        if (i_beat.wz) begin
            n_data = '0;
            n_data.w_zero = 1'b1;
        end else begin
            n_data.out_x      = res[0];
            n_data.out_y      = res[1];
            n_data.out_z      = res[2];
            n_data.w_zero     = 1'b0;
            n_data.overflowed = ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// File: hdl/homogeneous_point_transform_top.sv
// Homogeneous 4x4 point transform with perspective divide.
// Input channel (i_valid, o_ready, i_data) takes one Q16.16 point per beat;
// output channel (o_valid, i_ready, o_data) gives one transformed point per
// beat, in input order. The configuration port writes one of eight 64-bit
// matrix registers per cycle when i_cfg_we is high; indexes above seven are
// ignored. Write it only while no beat is in flight.
// The pipeline has four front stages (multiply, sum, magnitude, range
// check), one divider stage per quotient bit, and the rounding and
// saturation output register. Throughput is one beat per cycle while the
// output is not stalled; the divider row holds one beat in each stage, so
// a new point enters every cycle.
// When the receiver stalls, each stage holds its beat only while the stage
// after it is full, so empty stages keep filling and o_ready drops only once
// the whole pipeline is full.
// Synchronous reset empties the pipeline and loads the identity matrix.
`default_nettype none
module homogeneous_point_transform_top import hpt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_in                  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_out                      o_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    t_div_beat w_beat [QB+1];
    logic      w_v    [QB+1];
    logic      w_rdy  [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cfg_reset(FRAC_BITS);
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(CFG_N)) begin
            r_cfg[i_cfg_idx[$clog2(CFG_N)-1:0]] <= i_cfg_data;
        end
    end

    hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_beat  (w_beat[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_div
        hpt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_beat  (w_beat[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_beat  (w_beat[k+1])
        );
    end

    hpt_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[QB]),
        .o_ready (w_rdy[QB]),
        .i_beat  (w_beat[QB]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// File: hdl/hpt_checker.sv
`default_nettype none
module hpt_checker import hpt_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_ready,
    input wire t_out o_data,
    input wire logic o_valid,
    input wire logic i_ready
);

    localparam logic [COORD_W-1:0] MAXV = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] MINV = {1'b1, {(COORD_W-1){1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed");

    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.w_zero |-> o_data.out_x == '0 && o_data.out_y == '0 &&
            o_data.out_z == '0 && !o_data.overflowed)
        else $error("zero w beat carries data");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflowed |->
            (o_data.out_x == MAXV || o_data.out_x == MINV ||
             o_data.out_y == MAXV || o_data.out_y == MINV ||
             o_data.out_z == MAXV || o_data.out_z == MINV))
        else $error("overflow flag without a saturated coordinate");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_data  (o_data),
    .o_valid (o_valid),
    .i_ready (i_ready)
);
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
    import hpt_pkg::*;

    localparam int LATENCY = COORD_W + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] IDX_R0_C01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] IDX_BAD = CFG_IDX_W'(9);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [CFG_W-1:0] matrix_regs [CFG_N];
    t_in pending_points[$];
    t_out expected_points[$];
    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;

    homogeneous_point_transform_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    function automatic logic signed [31:0] coef(int row, int col);
        logic [CFG_W-1:0] r;
        r = matrix_regs[row * 2 + col / 2];
        return (col % 2) ? r[63:32] : r[31:0];
    endfunction

    function automatic logic signed [159:0] round_div(logic signed [159:0] n,
                                                      logic signed [159:0] d);
        logic [159:0] mn;
        logic [159:0] md;
        logic [159:0] q;
        logic [159:0] r;
        mn = n < 0 ? -n : n;
        md = d < 0 ? -d : d;
        q = mn / md;
        r = mn % md;
        if ((r << 1) >= md) q = q + 1;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_out transform_point(t_in p);
        t_out res;
        logic signed [159:0] acc [4];
        logic signed [159:0] pt [3];
        logic signed [159:0] v;
        logic signed [159:0] one;
        logic signed [31:0] sat [3];
        bit divide;
        bit ovf;
        one = 160'sd1 <<< FRAC_BITS_DEF;
        pt[0] = p.point_x;
        pt[1] = p.point_y;
        pt[2] = p.point_z;
        for (int r = 0; r < 4; r++) begin
            acc[r] = 160'(coef(r, 3)) * one;
            for (int c = 0; c < 3; c++) acc[r] = acc[r] + 160'(coef(r, c)) * pt[c];
        end
        divide = !(coef(3, 0) == 0 && coef(3, 1) == 0 && coef(3, 2) == 0
                   && coef(3, 3) == 32'sd65536);
        res = '0;
        if (divide && acc[3] == 0) begin
            res.w_zero = 1'b1;
            return res;
        end
        ovf = 1'b0;
        for (int c = 0; c < 3; c++) begin
            v = divide ? round_div(acc[c] * one, acc[3]) : round_div(acc[c], one);
            if (v > 160'sd2147483647) begin
                ovf = 1'b1;
                v = 160'sd2147483647;
            end else if (v < -160'sd2147483648) begin
                ovf = 1'b1;
                v = -160'sd2147483648;
            end
            sat[c] = v[31:0];
        end
        res.out_x = sat[0];
        res.out_y = sat[1];
        res.out_z = sat[2];
        res.overflowed = ovf;
        return res;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
            3: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h00010000;
            1: return 32'h0;
            2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            expected_points.push_back(transform_point(in_data));
        end
        if (!rst_n || (in_valid && !in_ready)) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
            in_valid <= 1'b1;
            in_data <= pending_points.pop_front();
            send_gap <= rand_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected beat %h", out_data);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (out_data.out_x !== want.out_x) begin
                    $error("out_x exp %h got %h", want.out_x, out_data.out_x);
                    errors++;
                end
                if (out_data.out_y !== want.out_y) begin
                    $error("out_y exp %h got %h", want.out_y, out_data.out_y);
                    errors++;
                end
                if (out_data.out_z !== want.out_z) begin
                    $error("out_z exp %h got %h", want.out_z, out_data.out_z);
                    errors++;
                end
                if (out_data.w_zero !== want.w_zero) begin
                    $error("w_zero exp %b got %b", want.w_zero, out_data.w_zero);
                    errors++;
                end
                if (out_data.overflowed !== want.overflowed) begin
                    $error("overflowed exp %b got %b", want.overflowed,
                           out_data.overflowed);
                    errors++;
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx < CFG_N) matrix_regs[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        pending_points.push_back(p);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) queue_point(rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    initial begin
        matrix_regs[0] = 64'h0000_0000_0001_0000;
        matrix_regs[1] = '0;
        matrix_regs[2] = 64'h0001_0000_0000_0000;
        matrix_regs[3] = '0;
        matrix_regs[4] = '0;
        matrix_regs[5] = 64'h0000_0000_0001_0000;
        matrix_regs[6] = '0;
        matrix_regs[7] = 64'h0001_0000_0000_0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
        queue_point(32'h00018000, 32'hfffe8000, 32'h00000001);
        queue_point(32'h80000000, 32'h7fffffff, 32'h00010000);
        drain();

        write_reg(IDX_R0_C01, 64'h0000_0000_0002_0000);
        write_reg(IDX_R3_C01, '0);
        write_reg(IDX_R3_C23, 64'h0001_0000_0000_0000);
        write_reg(IDX_BAD, '1);
        queue_point(32'h7fffffff, 32'h0, 32'h0);
        queue_point(32'h80000000, 32'h1, 32'h2);
        drain();

        write_reg(IDX_R3_C23, 64'h0000_0000_0001_0000);
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h00010000, 32'h0, 32'h0);
        queue_point(32'h00020000, 32'h00030000, 32'hffff0000);
        queue_point(32'h0000ffff, 32'h7fffffff, 32'h80000000);
        drain();

        write_reg(IDX_R3_C01, 64'h0000_0000_0000_0001);
        write_reg(IDX_R3_C23, 64'h0001_0000_0000_0000);
        random_phase(60);

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < CFG_N; k++)
                write_reg(CFG_IDX_W'(k), {rand_coef(), rand_coef()});
            if (ph == 1) write_reg(IDX_R3_C01, '0);
            if (ph == 2) write_reg(IDX_R3_C23, 64'h0001_0000_0000_0000);
            if (ph == 3) write_reg(IDX_R3_C01, '1);
            if (ph == 4) begin
                for (int k = 0; k < CFG_N; k++) write_reg(CFG_IDX_W'(k), '1);
            end
            random_phase(60);
        end
        for (int k = 0; k < CFG_N; k++) write_reg(CFG_IDX_W'(k), 64'h8000_0000_7fff_ffff);
        random_phase(15);

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
